// ----- rtl/ecpc_pkg.sv -----
// package for the escape count palette colorizer
// types, widths, codes and constants shared by the rtl and the checker
// no dependencies
package ecpc_pkg;

   // default sizes for the top level parameters
   localparam int PALETTE_DEPTH_DEF    = 256;
   localparam int MAX_OVERSAMPLING_DEF = 8;

   // fixed field widths
   localparam int COUNT_W  = 30;
   localparam int OFFSET_W = 32;
   localparam int SPEED_W  = 24;
   localparam int SIZE_W   = 9;
   localparam int OS_W     = 4;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 3 * CHAN_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // position arithmetic: s = count.16 + offset, p = s * speed
   localparam int FRAC_W  = 16;
   localparam int S_W     = COUNT_W + FRAC_W + 1;
   localparam int MUL_W   = 24;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int UPPER_W = S_W;
   localparam int IPART_W = S_W + SPEED_W - 32;
   localparam int STEP_W  = $clog2(IPART_W + 1);
   localparam int BLEND_W = CHAN_W + FRAC_W + 1;

   localparam logic [FRAC_W:0] FRAC_ONE = (FRAC_W + 1)'(1 << FRAC_W);

   // register reset values
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(1 << FRAC_W);

   // opcodes
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   // channel select
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // fixed colors
   localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;
   localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIGHLIGHT    = 3'd0,
      CSR_OVERSAMPLING = 3'd1,
      CSR_PAL_SIZE     = 3'd2,
      CSR_OFFSET       = 3'd3,
      CSR_SPEED        = 3'd4
   } ecpc_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_MOD_WAIT,
      ST_RD1,
      ST_RD2,
      ST_BL_A,
      ST_BL_B,
      ST_BL_C,
      ST_ACCUM,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_OUT
   } ecpc_state_type;

   // divider launch control
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } ecpc_div_ctl_type;

endpackage

// ----- rtl/escape_count_palette_colorizer.sv -----
// top level of the escape count palette colorizer
// sequencer, shared 24x24 multiplier, palette memory and pixel accumulator
// depends on ecpc_pkg and ecpc_divider
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  opcode, count, flags, palette write
//   rsp_      out        rsp_valid / rsp_stall  pixel_red, pixel_green, pixel_blue
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// a palette write is taken while idle; a fixed-color sample goes straight to the accumulator. a gradient
// sample waits for the bit-serial modulo in the shared divider. a sample that closes a pixel also
// runs the three channel averages on the same divider.
// reset is synchronous; no clearing pass, the palette is undefined until written.
// a finished pixel waits in the output register while the next item is taken;
// only a second finished pixel waits for rsp_stall to drop.
module escape_count_palette_colorizer
   import ecpc_pkg::*;
#(
   parameter int PALETTE_DEPTH    = PALETTE_DEPTH_DEF,
   parameter int MAX_OVERSAMPLING = MAX_OVERSAMPLING_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [COUNT_W-1:0]     req_iteration_count,
   input  logic                   req_guessed,
   input  logic                   req_in_set,
   input  logic [7:0]             req_palette_index,
   input  logic [CHAN_W-1:0]      req_palette_red,
   input  logic [CHAN_W-1:0]      req_palette_green,
   input  logic [CHAN_W-1:0]      req_palette_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAN_W-1:0]      rsp_pixel_red,
   output logic [CHAN_W-1:0]      rsp_pixel_green,
   output logic [CHAN_W-1:0]      rsp_pixel_blue,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // derived sizes
   localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
   localparam int EXT_W   = ((ADDR_W > 8) ? ADDR_W : 8) + 1;
   localparam int NUM_W   = $clog2(PALETTE_DEPTH + 1);
   localparam int CMP_W   = (NUM_W > SIZE_W) ? NUM_W : SIZE_W;
   localparam int SMP_W   = $clog2(MAX_OVERSAMPLING * MAX_OVERSAMPLING + 1);
   localparam int DIV_W   = (NUM_W > SMP_W) ? NUM_W : SMP_W;
   localparam int SUM_W   = $clog2(255 * MAX_OVERSAMPLING * MAX_OVERSAMPLING + 1);
   localparam int CNT_W   = SMP_W;
   localparam int SQ_W    = 2 * (OS_W + 1);

   // state and control
   ecpc_state_type         state_ff, state_in;
   logic [1:0]             ch_ff, ch_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // configuration
   logic                   highlight_ff, highlight_in;
   logic [OS_W-1:0]        os_ff, os_in;
   logic [SIZE_W-1:0]      pal_size_ff, pal_size_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;

   // pixel accumulator
   logic [SUM_W-1:0]       red_sum_ff, red_sum_in;
   logic [SUM_W-1:0]       green_sum_ff, green_sum_in;
   logic [SUM_W-1:0]       blue_sum_ff, blue_sum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // datapath registers
   logic [S_W-1:0]         s_ff, s_in;
   logic [PROD_W-1:0]      plo_ff, plo_in;
   logic [FRAC_W-1:0]      r_ff, r_in;
   logic [COLOR_W-1:0]     c1_ff, c1_in;
   logic [BLEND_W-1:0]     acc_ff, acc_in;
   logic [COLOR_W-1:0]     color_ff, color_in;
   logic [COLOR_W-1:0]     avg_ff, avg_in;
   logic [COLOR_W-1:0]     pix_ff, pix_in;

   // shared multiplier
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [PROD_W-1:0]      prod_ff;

   // palette memory
   logic [COLOR_W-1:0]     pal_mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0]     pal_rd_ff;
   logic                   pal_we;
   logic [ADDR_W-1:0]      pal_wa;
   logic [ADDR_W-1:0]      pal_ra;
   logic [EXT_W-1:0]       idx_ext;

   // divider
   ecpc_div_ctl_type       div_ctl;
   logic [IPART_W-1:0]     div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic                   div_done;
   logic [IPART_W-1:0]     div_quotient;
   logic [DIV_W-1:0]       div_remainder;

   // misc combinational
   logic                   req_take;
   logic                   csr_take;
   logic [CMP_W-1:0]       size_ext;
   logic [CMP_W-1:0]       size_clamp;
   logic [DIV_W-1:0]       n_mod;
   logic [OS_W:0]          os_clamp;
   logic [SQ_W-1:0]        samples;
   logic [CNT_W-1:0]       cnt_next;
   logic [UPPER_W-1:0]     upper;
   logic [DIV_W:0]         i_inc;
   logic [DIV_W-1:0]       i2;
   logic [BLEND_W-1:0]     blend_sum;
   logic [SUM_W-1:0]       sum_sel;
   logic                   need_gradient;
   logic [COLOR_W-1:0]     fixed_color;

   function automatic logic [CHAN_W-1:0] chan_byte(input logic [COLOR_W-1:0] c,
                                                   input logic [1:0] ch);
      logic [CHAN_W-1:0] b;
      case (ch)
         CH_RED:   b = c[23:16];
         CH_GREEN: b = c[15:8];
         default:  b = c[7:0];
      endcase
      return b;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;

   // palette size, zero taken as one, saturated at the depth
   assign size_ext   = CMP_W'(pal_size_ff);
   assign size_clamp = (size_ext == '0) ? CMP_W'(1) :
                       (size_ext > CMP_W'(PALETTE_DEPTH)) ? CMP_W'(PALETTE_DEPTH) : size_ext;
   assign n_mod      = DIV_W'(size_clamp);

   // samples per pixel
   assign os_clamp = (os_ff == '0) ? (OS_W + 1)'(1) :
                     ({1'b0, os_ff} > (OS_W + 1)'(MAX_OVERSAMPLING)) ?
                     (OS_W + 1)'(MAX_OVERSAMPLING) : {1'b0, os_ff};
   assign samples  = SQ_W'(os_clamp) * SQ_W'(os_clamp);
   assign cnt_next = cnt_ff + CNT_W'(1);

   // p[70:24] from the two partial products
   assign upper = UPPER_W'(plo_ff[PROD_W-1:MUL_W]) + prod_ff[UPPER_W-1:0];

   // second palette index wraps to zero at the palette size
   assign i_inc = {1'b0, div_remainder} + (DIV_W + 1)'(1);
   assign i2    = (i_inc == {1'b0, n_mod}) ? '0 : i_inc[DIV_W-1:0];

   assign blend_sum = acc_ff + prod_ff[BLEND_W-1:0];

   // palette write decode, indices past the depth are dropped
   assign idx_ext = EXT_W'(req_palette_index);
   assign pal_we  = req_take && (req_opcode == OP_PAL_WRITE) &&
                    (idx_ext < EXT_W'(PALETTE_DEPTH));
   assign pal_wa  = idx_ext[ADDR_W-1:0];
   // first entry while the modulo finishes, then the second entry, which the
   // read register keeps through all three blends
   assign pal_ra  = (state_ff == ST_MOD_WAIT || state_ff == ST_RD1) ?
                    div_remainder[ADDR_W-1:0] : i2[ADDR_W-1:0];

   // sample classification
   always_comb begin
      need_gradient = 1'b0;
      fixed_color   = COLOR_BLACK;
      if (highlight_ff) begin
         if (req_in_set && !req_guessed) begin
            fixed_color = COLOR_RED;
         end else if (req_in_set) begin
            fixed_color = COLOR_BLUE;
         end else if (req_guessed) begin
            fixed_color = COLOR_GREEN;
         end else begin
            need_gradient = 1'b1;
         end
      end else begin
         need_gradient = !req_in_set;
      end
   end

   always_comb begin
      case (ch_ff)
         CH_RED:   sum_sel = red_sum_ff;
         CH_GREEN: sum_sel = green_sum_ff;
         default:  sum_sel = blue_sum_ff;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_LO: begin
            mul_a = s_ff[MUL_W-1:0];
            mul_b = speed_ff;
         end
         ST_MUL_HI: begin
            mul_a = MUL_W'(s_ff[S_W-1:MUL_W]);
            mul_b = speed_ff;
         end
         ST_BL_A: begin
            // c1 * (1 - r)
            mul_a = MUL_W'(chan_byte(c1_ff, ch_ff));
            mul_b = MUL_W'(FRAC_ONE - {1'b0, r_ff});
         end
         ST_BL_B: begin
            // c2 * r, c2 sits in the read register
            mul_a = MUL_W'(chan_byte(pal_rd_ff, ch_ff));
            mul_b = MUL_W'(r_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      highlight_in  = highlight_ff;
      os_in         = os_ff;
      pal_size_in   = pal_size_ff;
      offset_in     = offset_ff;
      speed_in      = speed_ff;
      red_sum_in    = red_sum_ff;
      green_sum_in  = green_sum_ff;
      blue_sum_in   = blue_sum_ff;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      plo_in        = plo_ff;
      r_in          = r_ff;
      c1_in         = c1_ff;
      acc_in        = acc_ff;
      color_in      = color_ff;
      avg_in        = avg_ff;
      pix_in        = pix_ff;
      div_ctl.start = 1'b0;
      div_ctl.steps = STEP_W'(IPART_W);
      div_dividend  = upper[UPPER_W-1:UPPER_W-IPART_W];
      div_divisor   = n_mod;

      if (csr_take) begin
         unique case (csr_index)
            CSR_HIGHLIGHT:    highlight_in = csr_data[0];
            CSR_OVERSAMPLING: begin
               // new oversampling drops any partial pixel
               os_in        = csr_data[OS_W-1:0];
               red_sum_in   = '0;
               green_sum_in = '0;
               blue_sum_in  = '0;
               cnt_in       = '0;
            end
            CSR_PAL_SIZE:     pal_size_in = csr_data[SIZE_W-1:0];
            CSR_OFFSET:       offset_in   = csr_data[OFFSET_W-1:0];
            CSR_SPEED:        speed_in    = csr_data[SPEED_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_opcode == OP_SAMPLE)) begin
               s_in = {1'b0, req_iteration_count, FRAC_W'(0)} + S_W'(offset_ff);
               if (need_gradient) begin
                  state_in = ST_MUL_LO;
               end else begin
                  color_in = fixed_color;
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: begin
            plo_in   = prod_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // integer part goes to the divider for the palette modulo
            r_in          = {upper[7:0], plo_ff[MUL_W-1:FRAC_W]};
            div_ctl.start = 1'b1;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (div_done) begin
               state_in = ST_RD1;
            end
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: begin
            c1_in    = pal_rd_ff;
            ch_in    = CH_RED;
            state_in = ST_BL_A;
         end
         ST_BL_A: state_in = ST_BL_B;
         ST_BL_B: begin
            acc_in   = prod_ff[BLEND_W-1:0];
            state_in = ST_BL_C;
         end
         ST_BL_C: begin
            case (ch_ff)
               CH_RED:   color_in[23:16] = {blend_sum[23:17], 1'b1};
               CH_GREEN: color_in[15:8]  = {blend_sum[23:17], 1'b1};
               default:  color_in[7:0]   = {blend_sum[23:17], 1'b1};
            endcase
            if (ch_ff == CH_BLUE) begin
               ch_in    = CH_RED;
               state_in = ST_ACCUM;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_BL_A;
            end
         end
         ST_ACCUM: begin
            red_sum_in   = red_sum_ff + SUM_W'(color_ff[23:16]);
            green_sum_in = green_sum_ff + SUM_W'(color_ff[15:8]);
            blue_sum_in  = blue_sum_ff + SUM_W'(color_ff[7:0]);
            cnt_in       = cnt_next;
            ch_in        = CH_RED;
            if (SQ_W'(cnt_next) >= samples) begin
               state_in = ST_AVG_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_AVG_GO: begin
            // channel sum, left aligned, divided by the sample count
            div_ctl.start = 1'b1;
            div_ctl.steps = STEP_W'(SUM_W);
            div_dividend  = IPART_W'(sum_sel) << (IPART_W - SUM_W);
            div_divisor   = DIV_W'(samples);
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               case (ch_ff)
                  CH_RED:   avg_in[23:16] = div_quotient[CHAN_W-1:0];
                  CH_GREEN: avg_in[15:8]  = div_quotient[CHAN_W-1:0];
                  default:  avg_in[7:0]   = div_quotient[CHAN_W-1:0];
               endcase
               if (ch_ff == CH_BLUE) begin
                  ch_in    = CH_RED;
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_AVG_GO;
               end
            end
         end
         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               pix_in       = avg_ff;
               rsp_valid_in = 1'b1;
               red_sum_in   = '0;
               green_sum_in = '0;
               blue_sum_in  = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff        <= CH_RED;
         rsp_valid_ff <= 1'b0;
         highlight_ff <= 1'b0;
         os_ff        <= OS_W'(1);
         pal_size_ff  <= SIZE_W'(1);
         offset_ff    <= '0;
         speed_ff     <= SPEED_RESET;
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         cnt_ff       <= '0;
      end else begin
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         highlight_ff <= highlight_in;
         os_ff        <= os_in;
         pal_size_ff  <= pal_size_in;
         offset_ff    <= offset_in;
         speed_ff     <= speed_in;
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      plo_ff   <= plo_in;
      r_ff     <= r_in;
      c1_ff    <= c1_in;
      acc_ff   <= acc_in;
      color_ff <= color_in;
      avg_ff   <= avg_in;
      pix_ff   <= pix_in;
      prod_ff  <= mul_a * mul_b;
   end

   // palette store, at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_wa] <= {req_palette_red, req_palette_green, req_palette_blue};
      end
      pal_rd_ff <= pal_mem[pal_ra];
   end

   ecpc_divider #(
      .DIV_W (DIV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_red   = pix_ff[23:16];
   assign rsp_pixel_green = pix_ff[15:8];
   assign rsp_pixel_blue  = pix_ff[7:0];

endmodule

// ----- rtl/ecpc_divider.sv -----
// restoring divider, one quotient bit per cycle, dividend left aligned
// depends on ecpc_pkg
module ecpc_divider
   import ecpc_pkg::*;
#(
   parameter int DIV_W = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ecpc_div_ctl_type     ctl,
   input  logic [IPART_W-1:0]   dividend,
   input  logic [DIV_W-1:0]     divisor,
   output logic                 done,
   output logic [IPART_W-1:0]   quotient,
   output logic [DIV_W-1:0]     remainder
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [IPART_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_W:0]      trial;
   logic [DIV_W:0]      diff;
   logic                ge;

   assign trial = {rem_ff, dvd_ff[IPART_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[IPART_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/ecpc_checker.sv -----
// port level checks for the escape count palette colorizer
// depends on ecpc_pkg; bound to escape_count_palette_colorizer below
module ecpc_checker
   import ecpc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   req_opcode,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [CHAN_W-1:0]      rsp_pixel_red,
   input logic [CHAN_W-1:0]      rsp_pixel_green,
   input logic [CHAN_W-1:0]      rsp_pixel_blue,
   input logic                   csr_ready
);

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_red) &&
      $stable(rsp_pixel_green) && $stable(rsp_pixel_blue))
      else $error("pixel changed while stalled");

   // a sample keeps the block busy once it is taken
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_SAMPLE) |=> req_stall)
      else $error("not busy after sample");

   // a palette write finishes in its own cycle
   a_pal_write: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_PAL_WRITE) |=> !req_stall)
      else $error("busy after palette write");

   // a new pixel only comes out of work in progress
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("pixel without a sample in work");

   // configuration only while idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("config open while busy");

endmodule

bind escape_count_palette_colorizer ecpc_checker u_checker (.*);

// ----- test/tb_escape_count_palette_colorizer.sv -----
`timescale 1ns / 100ps
// self-checking bench for escape_count_palette_colorizer: palette writes, directed and
// random samples, per-sample color prediction and pixel averaging against rsp items
// depends on ecpc_pkg and the colorizer rtl
module tb_escape_count_palette_colorizer
   import ecpc_pkg::*;
();

   localparam int CYCLE_LIMIT   = 1000000;
   // quiet time that covers a gradient sample plus the three averaging divisions
   localparam int SETTLE_CYCLES = 250;
   localparam int SQUEEZE_CYCLES = 900;

   typedef struct {
      logic              op;
      logic [COUNT_W-1:0] count;
      logic              guessed;
      logic              in_set;
      logic [7:0]        index;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      bit                hold_back;   // wait for all pixels before offering this item
   } colorizer_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_SAMPLE;
   logic [COUNT_W-1:0]    req_iteration_count = '0;
   logic                  req_guessed = 1'b0;
   logic                  req_in_set = 1'b0;
   logic [7:0]            req_palette_index = '0;
   logic [CHAN_W-1:0]     req_palette_red = '0;
   logic [CHAN_W-1:0]     req_palette_green = '0;
   logic [CHAN_W-1:0]     req_palette_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_pixel_red;
   logic [CHAN_W-1:0]     rsp_pixel_green;
   logic [CHAN_W-1:0]     rsp_pixel_blue;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   ecpc_csr_type          csr_index = CSR_HIGHLIGHT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   escape_count_palette_colorizer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_iteration_count(req_iteration_count),
      .req_guessed        (req_guessed),
      .req_in_set         (req_in_set),
      .req_palette_index  (req_palette_index),
      .req_palette_red    (req_palette_red),
      .req_palette_green  (req_palette_green),
      .req_palette_blue   (req_palette_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_red      (rsp_pixel_red),
      .rsp_pixel_green    (rsp_pixel_green),
      .rsp_pixel_blue     (rsp_pixel_blue),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // items waiting for the driver, and pixels predicted but not yet seen
   colorizer_item_type pending_items[$];
   pixel_type          pixels_due[$];
   colorizer_item_type on_wire;

   // shadow registers and state of the colorizer
   logic                highlight_on = 1'b0;
   logic [OS_W-1:0]     os_setting = OS_W'(1);
   logic [SIZE_W-1:0]   size_setting = SIZE_W'(1);
   logic [OFFSET_W-1:0] offset_setting = '0;
   logic [SPEED_W-1:0]  speed_setting = SPEED_RESET;
   logic [COLOR_W-1:0]  palette_copy [PALETTE_DEPTH_DEF];
   int unsigned         red_acc = 0;
   int unsigned         green_acc = 0;
   int unsigned         blue_acc = 0;
   int unsigned         samples_taken = 0;

   // entries already queued for writing, so gradient samples never hit a blank entry
   bit painted [PALETTE_DEPTH_DEF];

   int  idle_level = 0;   // 0 none, 1 now and then, 2 every item
   int  send_gap = 0;
   int  stall_left = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  squeeze_go = 1'b0;
   logic squeeze = 1'b0;
   pixel_type want_px;
   pixel_type got_px;
   string chan_name [3] = '{"red", "green", "blue"};

   function automatic int draw_wait();
      case (idle_level)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) : 0;
         default: return int'($urandom_range(0, 6));
      endcase
   endfunction

   // truncated blend of two channel values by a 16-bit fraction, low bit forced
   function automatic logic [CHAN_W-1:0] blend(input int unsigned a, input int unsigned b,
                                               input int unsigned ratio);
      int unsigned v;
      v = (a * (32'd65536 - ratio) + b * ratio) >> FRAC_W;
      return CHAN_W'(v) | CHAN_W'(1);
   endfunction

   // color one accepted item and push the pixel it completes, if any
   function automatic void colorize(input colorizer_item_type it);
      logic [46:0]        pos_in;
      logic [70:0]        pos;
      logic [38:0]        whole;
      int unsigned        ratio;
      int unsigned        n;
      int unsigned        i1;
      int unsigned        i2;
      int unsigned        os;
      int unsigned        samples;
      logic [COLOR_W-1:0] c1;
      logic [COLOR_W-1:0] c2;
      logic [COLOR_W-1:0] color;
      if (it.op == OP_PAL_WRITE) begin
         palette_copy[it.index] = {it.red, it.green, it.blue};
         return;
      end
      if (highlight_on && it.in_set && !it.guessed) color = COLOR_RED;
      else if (highlight_on && it.in_set) color = COLOR_BLUE;
      else if (highlight_on && it.guessed) color = COLOR_GREEN;
      else if (it.in_set) color = COLOR_BLACK;
      else begin
         // position = (count.16 + offset) * speed, exact, Q39.32
         pos_in = (47'(it.count) << FRAC_W) + 47'(offset_setting);
         pos = 71'(pos_in) * 71'(speed_setting);
         whole = pos[70:32];
         ratio = 32'(pos[31:16]);
         n = (size_setting == 0) ? 1 :
             (size_setting > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : 32'(size_setting);
         i1 = int'(whole % 39'(n));
         i2 = (i1 + 1) % n;
         c1 = palette_copy[i1];
         c2 = palette_copy[i2];
         color = {blend(c1[23:16], c2[23:16], ratio), blend(c1[15:8], c2[15:8], ratio),
                  blend(c1[7:0], c2[7:0], ratio)};
      end
      red_acc += color[23:16];
      green_acc += color[15:8];
      blue_acc += color[7:0];
      samples_taken++;
      os = (os_setting == 0) ? 1 :
           (os_setting > MAX_OVERSAMPLING_DEF) ? MAX_OVERSAMPLING_DEF : 32'(os_setting);
      samples = os * os;
      if (samples_taken >= samples) begin
         pixels_due.push_back('{CHAN_W'(red_acc / samples), CHAN_W'(green_acc / samples),
                                CHAN_W'(blue_acc / samples)});
         red_acc = 0;
         green_acc = 0;
         blue_acc = 0;
         samples_taken = 0;
      end
   endfunction

   // driver: one item per handshake, a drawn gap after each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) colorize(on_wire);
         // a stalled item stays on the wire unchanged
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].hold_back && pixels_due.size() != 0)) begin
               on_wire = pending_items.pop_front();
               req_valid <= 1'b1;
               req_opcode <= on_wire.op;
               req_iteration_count <= on_wire.count;
               req_guessed <= on_wire.guessed;
               req_in_set <= on_wire.in_set;
               req_palette_index <= on_wire.index;
               req_palette_red <= on_wire.red;
               req_palette_green <= on_wire.green;
               req_palette_blue <= on_wire.blue;
               send_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each pixel with the oldest prediction, then draw the stall
   // that the next pixel will see
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_px = {rsp_pixel_red, rsp_pixel_green, rsp_pixel_blue};
            if (pixels_due.size() == 0) begin
               mismatches++;
               $display("%0t unexpected pixel %02h %02h %02h", $time,
                        got_px.red, got_px.green, got_px.blue);
            end else begin
               want_px = pixels_due.pop_front();
               for (int ch = 0; ch < 3; ch++) begin
                  if (got_px[23 - 8 * ch -: 8] !== want_px[23 - 8 * ch -: 8]) begin
                     mismatches++;
                     $display("%0t pixel %s: expected %02h, got %02h", $time, chan_name[ch],
                              want_px[23 - 8 * ch -: 8], got_px[23 - 8 * ch -: 8]);
                  end
               end
            end
            stall_left = draw_wait();
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= squeeze || (stall_left > 0);
      end
   end

   // long receiver hold-off so the block fills up and pushes back on req
   initial begin
      wait (squeeze_go);
      @(posedge clock);
      squeeze <= 1'b1;
      repeat (SQUEEZE_CYCLES) @(posedge clock);
      squeeze <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void push_write(input logic [7:0] index, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue);
      colorizer_item_type it;
      it.op = OP_PAL_WRITE;
      // sample fields ride along as noise
      it.count = COUNT_W'($urandom);
      it.guessed = 1'($urandom);
      it.in_set = 1'($urandom);
      it.index = index;
      it.red = red;
      it.green = green;
      it.blue = blue;
      it.hold_back = 1'b0;
      painted[index] = 1'b1;
      pending_items.push_back(it);
   endfunction

   function automatic void push_sample(input logic [COUNT_W-1:0] count, input logic guessed,
                                       input logic in_set);
      colorizer_item_type it;
      it.op = OP_SAMPLE;
      it.count = count;
      it.guessed = guessed;
      it.in_set = in_set;
      // palette fields are ignored on a sample
      it.index = 8'($urandom);
      it.red = 8'($urandom);
      it.green = 8'($urandom);
      it.blue = 8'($urandom);
      it.hold_back = 1'b0;
      pending_items.push_back(it);
   endfunction

   // block has nothing queued, nothing owed, and time to finish a silent sample
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || pixels_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; bits above the register width carry random junk
   task automatic write_reg(input ecpc_csr_type which, input logic [31:0] value,
                            input logic [31:0] keep);
      logic [31:0] data;
      data = (value & keep) | ($urandom & ~keep);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (which)
         CSR_HIGHLIGHT: highlight_on = data[0];
         CSR_OVERSAMPLING: begin
            // rewriting oversampling drops a partial pixel
            os_setting = data[OS_W-1:0];
            red_acc = 0;
            green_acc = 0;
            blue_acc = 0;
            samples_taken = 0;
         end
         CSR_PAL_SIZE: size_setting = data[SIZE_W-1:0];
         CSR_OFFSET: offset_setting = data;
         CSR_SPEED: speed_setting = data[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   // one random phase: idle, program every register, fill the active palette, queue items
   task automatic run_phase(input logic hl, input logic [3:0] os, input logic [8:0] size,
                            input logic [31:0] offset, input logic [23:0] speed,
                            input int n_items, input int idle, input bit pauses);
      int n;
      int i;
      logic [COUNT_W-1:0] count;
      wait_idle();
      idle_level = idle;
      write_reg(CSR_HIGHLIGHT, 32'(hl), 32'h1);
      write_reg(CSR_OVERSAMPLING, 32'(os), 32'hF);
      write_reg(CSR_PAL_SIZE, 32'(size), 32'h1FF);
      write_reg(CSR_OFFSET, offset, 32'hFFFF_FFFF);
      write_reg(CSR_SPEED, 32'(speed), 32'hFF_FFFF);
      n = (size == 0) ? 1 : (size > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : 32'(size);
      for (i = 0; i < n; i++)
         if (!painted[i]) push_write(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            push_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            // full range, low counts, counts near the top, mid counts
            case ($urandom_range(0, 3))
               0: count = COUNT_W'($urandom);
               1: count = COUNT_W'($urandom_range(0, 300));
               2: count = {COUNT_W{1'b1}} - COUNT_W'($urandom_range(0, 300));
               default: count = COUNT_W'($urandom_range(0, 65535));
            endcase
            push_sample(count, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
         end
         // at least one pause mid phase, more at random
         if (pauses && (i == n_items / 2 || $urandom_range(0, 39) == 0))
            pending_items[$].hold_back = 1'b1;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: one entry in use, speed 1.0
      idle_level = 0;
      push_write(8'd0, 8'hFF, 8'h00, 8'hFF);
      push_write(8'd255, 8'h00, 8'hFF, 8'h00);
      push_sample(30'd0, 1'b0, 1'b0);
      push_sample(30'h3FFF_FFFF, 1'b0, 1'b0);
      push_sample(30'd5, 1'b0, 1'b1);          // inside, black
      push_sample(30'd5, 1'b1, 1'b0);          // guessed flag ignored without highlight
      push_sample(30'd5, 1'b1, 1'b1);

      // directed, highlight on with a two-entry palette at half speed
      wait_idle();
      write_reg(CSR_HIGHLIGHT, 32'd1, 32'h1);
      write_reg(CSR_PAL_SIZE, 32'd2, 32'h1FF);
      write_reg(CSR_SPEED, 32'h8000, 32'hFF_FFFF);
      push_write(8'd1, 8'h80, 8'h7F, 8'h01);
      push_sample(30'd3, 1'b0, 1'b1);          // red
      push_sample(30'd3, 1'b1, 1'b1);          // blue
      push_sample(30'd3, 1'b1, 1'b0);          // green
      push_sample(30'd1, 1'b0, 1'b0);          // halfway between entries 0 and 1
      push_sample(30'd0, 1'b0, 1'b0);

      // random phases through the register extremes
      run_phase(1'b0, 4'd1, 9'd4, 32'h0000_0000, 24'h01_0000, 120, 2, 1'b0);
      run_phase(1'b1, 4'd2, 9'd16, 32'h0001_8000, 24'h00_C000, 120, 0, 1'b0);
      run_phase(1'b0, 4'd0, 9'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 100, 1, 1'b0);
      run_phase(1'b1, 4'd3, 9'd256, 32'h1234_5678, 24'h00_4000, 100, 2, 1'b0);
      run_phase(1'b0, 4'd8, 9'd300, 32'h0000_FFFF, 24'h00_0001, 160, 1, 1'b0);
      run_phase(1'b1, 4'd15, 9'd511, 32'h8000_0000, 24'h80_0000, 120, 2, 1'b0);
      // receiver holds off while this phase streams in
      run_phase(1'b0, 4'd1, 9'd7, $urandom, 24'($urandom), 150, 1, 1'b0);
      squeeze_go = 1'b1;
      // sender waits for every pixel now and then
      run_phase(1'b1, 4'd2, 9'd255, $urandom, 24'($urandom), 150, 2, 1'b1);
      run_phase(1'b0, 4'd4, 9'd33, $urandom, 24'h00_0000, 100, 0, 1'b0);
      run_phase(1'b1, 4'd1, 9'd1, $urandom, 24'($urandom), 120, 1, 1'b0);

      wait_idle();
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
